// ----- rtl/core/rbs_pkg.sv -----
// Shared types and constants for the ray versus box slab test.
package rbs_pkg;

	localparam int AXES = 3;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_X = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Z = 3'd5;

	typedef struct packed {
		logic dir_zero;
		logic out_slab;
	} lane_flags_t;

endpackage

// ----- rtl/core/rbs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module rbs_div #(
	parameter int C = 32,
	parameter int F = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [C-1:0]     num,
	input  logic [C-1:0]     dmag,
	input  logic             neg,
	output logic [C+F-1:0]   quo,
	output logic             quo_neg
);
	localparam int W = C + F;

	logic [C-1:0] rem_q [W];
	logic [W-1:0] q_q   [W];
	logic [W-1:0] n_q   [W];
	logic [C-1:0] d_q   [W];
	logic         neg_q [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [C-1:0] rem_i;
		logic [C-1:0] d_i;
		logic [W-1:0] n_i;
		logic [W-1:0] q_i;
		logic         neg_i;
		logic [C:0]   trial;
		logic [C:0]   diff;
		logic         ge;

		if (k == 0) begin : g_first
			assign rem_i = '0;
			assign d_i   = dmag;
			assign n_i   = {num, {F{1'b0}}};
			assign q_i   = '0;
			assign neg_i = neg;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign d_i   = d_q[k-1];
			assign n_i   = n_q[k-1];
			assign q_i   = q_q[k-1];
			assign neg_i = neg_q[k-1];
		end

		assign trial = {rem_i, n_i[W-1]};
		assign ge    = trial >= {1'b0, d_i};
		assign diff  = trial - {1'b0, d_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[C-1:0] : trial[C-1:0];
				q_q[k]   <= {q_i[W-2:0], ge};
				n_q[k]   <= {n_i[W-2:0], 1'b0};
				d_q[k]   <= d_i;
				neg_q[k] <= neg_i;
			end
		end
	end

	assign quo     = q_q[W-1];
	assign quo_neg = neg_q[W-1];
endmodule

// ----- rtl/core/rbs_lane.sv -----
// One axis lane: slab plane distances, saturation and ordering.
module rbs_lane #(
	parameter int C = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic [C-1:0]        org_b,
	input  logic [C-1:0]        dir,
	input  logic [C-1:0]        bmin_b,
	input  logic [C-1:0]        bmax_b,
	output logic [C-1:0]        tn_b,
	output logic [C-1:0]        tf_b,
	output rbs_pkg::lane_flags_t flags
);
	localparam int W = C + F;
	localparam logic [C-1:0] SB = {1'b1, {(C-1){1'b0}}};
	localparam logic [C-1:0] SBM = SB - 1'b1;

	logic [C-1:0] numn_s1, numf_s1, dmag_s1;
	logic         negn_s1, negf_s1;
	rbs_pkg::lane_flags_t flags_s1;
	rbs_pkg::lane_flags_t fl_q [W];

	logic [C-1:0] lo_b, hi_b;
	logic         d_neg, bn_lt, bf_lt;

	assign d_neg = dir[C-1];
	assign bn_lt = bmin_b < org_b;
	assign bf_lt = bmax_b < org_b;
	assign lo_b  = (bmin_b < bmax_b) ? bmin_b : bmax_b;
	assign hi_b  = (bmin_b < bmax_b) ? bmax_b : bmin_b;

	always_ff @(posedge clk) begin
		if (en) begin
			numn_s1  <= bn_lt ? (org_b - bmin_b) : (bmin_b - org_b);
			numf_s1  <= bf_lt ? (org_b - bmax_b) : (bmax_b - org_b);
			dmag_s1  <= d_neg ? (~dir + 1'b1) : dir;
			negn_s1  <= bn_lt ^ d_neg;
			negf_s1  <= bf_lt ^ d_neg;
			flags_s1.dir_zero <= (dir == '0);
			flags_s1.out_slab <= (org_b < lo_b) || (org_b > hi_b);
		end
	end

	logic [W-1:0] qn, qf;
	logic         qn_neg, qf_neg;

	rbs_div #(.C(C), .F(F)) u_div_near (
		.clk(clk), .en(en), .num(numn_s1), .dmag(dmag_s1), .neg(negn_s1),
		.quo(qn), .quo_neg(qn_neg)
	);

	rbs_div #(.C(C), .F(F)) u_div_far (
		.clk(clk), .en(en), .num(numf_s1), .dmag(dmag_s1), .neg(negf_s1),
		.quo(qf), .quo_neg(qf_neg)
	);

	for (genvar k = 0; k < W; k++) begin : g_flags
		always_ff @(posedge clk) begin
			if (en) begin
				fl_q[k] <= (k == 0) ? flags_s1 : fl_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	function automatic logic [C-1:0] sat_b(input logic [W-1:0] q, input logic ng);
		logic [C-1:0] m;
		begin
			if (ng) begin
				m = (q > {{(W-C){1'b0}}, SB}) ? SB : q[C-1:0];
				sat_b = SB - m;
			end else begin
				m = (q > {{(W-C){1'b0}}, SBM}) ? SBM : q[C-1:0];
				sat_b = SB + m;
			end
		end
	endfunction

	logic [C-1:0] dn_b, df_b;
	assign dn_b = sat_b(qn, qn_neg);
	assign df_b = sat_b(qf, qf_neg);

	always_ff @(posedge clk) begin
		if (en) begin
			tn_b  <= (dn_b > df_b) ? df_b : dn_b;
			tf_b  <= (dn_b > df_b) ? dn_b : df_b;
			flags <= fl_q[W-1];
		end
	end
endmodule

// ----- rtl/core/rbs_merge.sv -----
// Merge stage: narrows the ray interval over all lanes and forms the result.
module rbs_merge #(
	parameter int C = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [C-1:0]         t0_b,
	input  logic [C-1:0]         t1_b,
	input  logic [C-1:0]         tn_b  [rbs_pkg::AXES],
	input  logic [C-1:0]         tf_b  [rbs_pkg::AXES],
	input  rbs_pkg::lane_flags_t flags [rbs_pkg::AXES],
	output logic                 hit,
	output logic [C-1:0]         t_enter,
	output logic [C-1:0]         t_exit
);
	localparam logic [C-1:0] SB = {1'b1, {(C-1){1'b0}}};

	logic [C-1:0] lo, hi;
	logic         miss;

	always_comb begin
		lo   = t0_b;
		hi   = t1_b;
		miss = 1'b0;
		for (int a = 0; a < rbs_pkg::AXES; a++) begin
			if (flags[a].dir_zero) begin
				miss = miss | flags[a].out_slab;
			end else begin
				if (tn_b[a] > lo) lo = tn_b[a];
				if (tf_b[a] < hi) hi = tf_b[a];
			end
		end
		miss = miss | (lo > hi);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit     <= !miss;
			t_enter <= miss ? '0 : (lo ^ SB);
			t_exit  <= miss ? '0 : (hi ^ SB);
		end
	end
endmodule

// ----- rtl/core/ray_box_slab_test.sv -----
// Top level of the ray versus axis-aligned box slab test.
//
// Usage: write the six box corner registers on the cfg channel (cfg_index
// 0..2 lower corner x/y/z, 3..5 upper corner x/y/z; cfg_ready is always
// high, other indexes are dropped). Then stream rays on the input channel:
// a request is taken when in_valid is high and in_stall is low.
// Each ray gives exactly one result on the output channel: hit plus the
// narrowed interval t_enter/t_exit (both zero on a miss).
// Each lane passes a ray through an input register, the bit-per-stage
// divider pipeline and an output register; the merge stage registers last.
// Throughput is one ray per cycle while the output is not stalled; many rays are in flight at once.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; bubbles do not advance a held result.
// Reset clears all in-flight valid bits and the box registers to zero.
module ray_box_slab_test #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rbs_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]            cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [COORD_BITS-1:0]            origin_x,
	input  logic [COORD_BITS-1:0]            origin_y,
	input  logic [COORD_BITS-1:0]            origin_z,
	input  logic [COORD_BITS-1:0]            dir_x,
	input  logic [COORD_BITS-1:0]            dir_y,
	input  logic [COORD_BITS-1:0]            dir_z,
	input  logic [COORD_BITS-1:0]            t_min,
	input  logic [COORD_BITS-1:0]            t_max,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic [COORD_BITS-1:0]            t_enter,
	output logic [COORD_BITS-1:0]            t_exit
);
	localparam int C = COORD_BITS;
	localparam int W = COORD_BITS + FRAC_BITS;
	localparam int LAT = W + 3;
	localparam int TDLY = W + 2;
	localparam logic [C-1:0] SB = {1'b1, {(C-1){1'b0}}};

	logic [C-1:0] bmin_q [rbs_pkg::AXES];
	logic [C-1:0] bmax_q [rbs_pkg::AXES];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < rbs_pkg::AXES; a++) begin
				bmin_q[a] <= '0;
				bmax_q[a] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rbs_pkg::REG_MIN_X: bmin_q[0] <= cfg_data;
				rbs_pkg::REG_MIN_Y: bmin_q[1] <= cfg_data;
				rbs_pkg::REG_MIN_Z: bmin_q[2] <= cfg_data;
				rbs_pkg::REG_MAX_X: bmax_q[0] <= cfg_data;
				rbs_pkg::REG_MAX_Y: bmax_q[1] <= cfg_data;
				rbs_pkg::REG_MAX_Z: bmax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic [LAT-1:0] vld_q;

	assign en       = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	logic [C-1:0] org [rbs_pkg::AXES];
	logic [C-1:0] dir [rbs_pkg::AXES];
	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	logic [C-1:0] tn_b [rbs_pkg::AXES];
	logic [C-1:0] tf_b [rbs_pkg::AXES];
	rbs_pkg::lane_flags_t flags [rbs_pkg::AXES];

	for (genvar a = 0; a < rbs_pkg::AXES; a++) begin : g_lane
		rbs_lane #(.C(C), .F(FRAC_BITS)) u_lane (
			.clk(clk), .en(en),
			.org_b(org[a] ^ SB), .dir(dir[a]),
			.bmin_b(bmin_q[a] ^ SB), .bmax_b(bmax_q[a] ^ SB),
			.tn_b(tn_b[a]), .tf_b(tf_b[a]), .flags(flags[a])
		);
	end

	logic [C-1:0] t0_q [TDLY];
	logic [C-1:0] t1_q [TDLY];

	always_ff @(posedge clk) begin
		if (en) begin
			t0_q[0] <= t_min ^ SB;
			t1_q[0] <= t_max ^ SB;
			for (int k = 1; k < TDLY; k++) begin
				t0_q[k] <= t0_q[k-1];
				t1_q[k] <= t1_q[k-1];
			end
		end
	end

	rbs_merge #(.C(C)) u_merge (
		.clk(clk), .en(en),
		.t0_b(t0_q[TDLY-1]), .t1_b(t1_q[TDLY-1]),
		.tn_b(tn_b), .tf_b(tf_b), .flags(flags),
		.hit(hit), .t_enter(t_enter), .t_exit(t_exit)
	);
endmodule

// ----- rtl/core/rbs_checker.sv -----
// Port-level checks for the slab test block, bound to its top level.
module rbs_checker #(
	parameter int C = 32
) (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_ready,
	input logic         in_stall,
	input logic         out_valid,
	input logic         out_stall,
	input logic         hit,
	input logic [C-1:0] t_enter,
	input logic [C-1:0] t_exit
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(t_enter)
			&& $stable(t_exit))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> t_enter == '0 && t_exit == '0)
		else $error("miss with nonzero interval");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> $signed(t_enter) <= $signed(t_exit))
		else $error("hit with empty interval");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall) && cfg_ready)
		else $error("input stall does not follow output stall");
endmodule

bind ray_box_slab_test rbs_checker #(.C(COORD_BITS)) u_rbs_checker (
	.clk(clk), .arst_n(arst_n), .cfg_ready(cfg_ready),
	.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
	.hit(hit), .t_enter(t_enter), .t_exit(t_exit)
);

// ----- tb/sv/ray_box_slab_test_tb.sv -----
// Testbench for the ray versus box slab test: random and directed rays, checked against a predictor.
`timescale 1ns / 1ps
module ray_box_slab_test_tb;

	localparam int CB = 32;
	localparam int FB = 16;
	localparam int IDX_BITS = rbs_pkg::CFG_IDX_BITS;
	localparam int LATENCY = CB + FB + 3;
	localparam longint LIMIT = 2000000;

	typedef struct packed {
		logic [CB-1:0] ox, oy, oz, dx, dy, dz, tmin, tmax;
	} ray_t;

	typedef struct packed {
		logic          hit;
		logic [CB-1:0] t_enter, t_exit;
	} span_t;

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [IDX_BITS-1:0] cfg_index = rbs_pkg::REG_MIN_X;
	logic [CB-1:0] cfg_data = 0;
	logic in_valid = 0, in_stall;
	logic [CB-1:0] origin_x = 0, origin_y = 0, origin_z = 0;
	logic [CB-1:0] dir_x = 0, dir_y = 0, dir_z = 0, t_min = 0, t_max = 0;
	logic out_valid, out_stall = 0, hit;
	logic [CB-1:0] t_enter, t_exit;

	ray_box_slab_test uut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	logic signed [CB-1:0] box_lo [3];
	logic signed [CB-1:0] box_hi [3];
	ray_t pending_rays[$];
	span_t expected_spans[$];
	int errors = 0;
	int send_idle = 22, recv_idle = 69;
	bit hold_send = 0;
	longint cycles = 0;

	function automatic logic signed [CB-1:0] slab_dist(logic signed [CB-1:0] plane,
			logic signed [CB-1:0] org, logic signed [CB-1:0] d);
		logic signed [127:0] num, q;
		num = (128'(signed'(plane)) - 128'(signed'(org))) <<< FB;
		q = num / 128'(signed'(d));
		if (q > 128'(signed'({1'b0, {(CB-1){1'b1}}}))) return {1'b0, {(CB-1){1'b1}}};
		if (q < -128'(signed'({1'b0, {(CB-1){1'b1}}})) - 1) return {1'b1, {(CB-1){1'b0}}};
		return q[CB-1:0];
	endfunction

	function automatic span_t trace_box(ray_t r);
		logic signed [CB-1:0] t0, t1, tn, tf, org, d, lo, hi, s;
		bit miss;
		span_t res;
		t0 = r.tmin;
		t1 = r.tmax;
		miss = 0;
		for (int a = 0; a < 3; a++) begin
			org = (a == 0) ? r.ox : (a == 1) ? r.oy : r.oz;
			d = (a == 0) ? r.dx : (a == 1) ? r.dy : r.dz;
			if (d == 0) begin
				lo = (box_lo[a] < box_hi[a]) ? box_lo[a] : box_hi[a];
				hi = (box_lo[a] < box_hi[a]) ? box_hi[a] : box_lo[a];
				if (org < lo || org > hi) miss = 1;
			end else begin
				tn = slab_dist(box_lo[a], org, d);
				tf = slab_dist(box_hi[a], org, d);
				if (tn > tf) begin
					s = tn; tn = tf; tf = s;
				end
				if (tn > t0) t0 = tn;
				if (tf < t1) t1 = tf;
			end
			if (t0 > t1) miss = 1;
		end
		res = miss ? '0 : {1'b1, t0, t1};
		return res;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall) expected_spans.push_back(trace_box(
			{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max}));
		if (!(in_valid && in_stall)) begin
			if (arst_n && !hold_send && pending_rays.size() > 0 &&
					$urandom_range(99) >= send_idle) begin
				ray_t r;
				r = pending_rays.pop_front();
				{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max} <= r;
				in_valid <= 1;
			end else in_valid <= 0;
		end
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_spans.size() == 0) begin
				$display("%0t unexpected result hit=%0d %h %h", $time, hit, t_enter, t_exit);
				errors++;
			end else begin
				span_t e;
				e = expected_spans.pop_front();
				if (e.hit !== hit) begin
					$display("%0t hit exp %0d act %0d", $time, e.hit, hit);
					errors++;
				end
				if (e.t_enter !== t_enter) begin
					$display("%0t t_enter exp %h act %h", $time, e.t_enter, t_enter);
					errors++;
				end
				if (e.t_exit !== t_exit) begin
					$display("%0t t_exit exp %h act %h", $time, e.t_exit, t_exit);
					errors++;
				end
			end
		end
	end

	task automatic write_box(logic [IDX_BITS-1:0] idx, logic [CB-1:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= rbs_pkg::REG_MIN_Z) box_lo[idx] = v;
		else box_hi[idx - rbs_pkg::REG_MAX_X] = v;
	endtask

	task automatic drain();
		while (pending_rays.size() > 0 || in_valid || expected_spans.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [CB-1:0] pick_val();
		case ($urandom_range(7))
			0: return {1'b0, {(CB-1){1'b1}}};
			1: return {1'b1, {(CB-1){1'b0}}};
			2: return 0;
			3: return $urandom;
			default: return 32'($signed($urandom_range(40 << FB)) - (20 << FB));
		endcase
	endfunction

	function automatic ray_t random_ray();
		ray_t r;
		r.ox = pick_val(); r.oy = pick_val(); r.oz = pick_val();
		r.dx = ($urandom_range(5) == 0) ? 0 : pick_val();
		r.dy = ($urandom_range(5) == 0) ? 0 : pick_val();
		r.dz = ($urandom_range(5) == 0) ? 0 : pick_val();
		if ($urandom_range(4) == 0) begin
			r.tmin = pick_val(); r.tmax = pick_val();
		end else begin
			r.tmin = {1'b1, {(CB-1){1'b0}}}; r.tmax = {1'b0, {(CB-1){1'b1}}};
		end
		return r;
	endfunction

	task automatic set_box(int mode);
		logic [CB-1:0] v;
		for (int i = 0; i < 6; i++) begin
			case (mode)
				0: v = (i < 3) ? -(32'sd5 << FB) : (32'sd5 << FB);
				1: v = (i < 3) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
				2: v = (i < 3) ? (32'sd3 << FB) : -(32'sd3 << FB);
				default: v = pick_val();
			endcase
			write_box(IDX_BITS'(i), v);
		end
		cfg_valid <= 0;
	endtask

	initial begin
		ray_t r;
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = 0; box_hi[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_box(0);
		r = '{default: 0};
		r.tmin = {1'b1, {(CB-1){1'b0}}}; r.tmax = {1'b0, {(CB-1){1'b1}}};
		r.ox = -(32'sd10 << FB); r.dx = 32'sd1 << FB;
		pending_rays.push_back(r);
		r.dx = 1;
		pending_rays.push_back(r);
		r.dx = {1'b1, {(CB-1){1'b0}}};
		pending_rays.push_back(r);
		r.dx = 0;
		pending_rays.push_back(r);
		r.ox = 32'sd5 << FB;
		pending_rays.push_back(r);
		r.dx = -1; r.ox = {1'b0, {(CB-1){1'b1}}};
		pending_rays.push_back(r);
		r.tmin = 32'sd4; r.tmax = 32'sd2;
		pending_rays.push_back(r);
		r = '1;
		pending_rays.push_back(r);
		for (int i = 0; i < 12; i++) pending_rays.push_back(random_ray());
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			set_box(ph == 0 ? 1 : ph == 1 ? 2 : 3);
			if (ph == 2) begin
				send_idle = 69; recv_idle = 22;
			end else if (ph == 4) begin
				send_idle = 0; recv_idle = 0;
			end
			for (int i = 0; i < 220; i++) pending_rays.push_back(random_ray());
			if (ph == 3) begin
				while (pending_rays.size() > 110) @(posedge clk);
				hold_send = 1;
				while (in_valid || expected_spans.size() > 0) @(posedge clk);
				hold_send = 0;
			end
			drain();
		end
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
